/* rtl/slt_pkg.sv */
// ----------------------------------------------------------------------------
// slt_pkg
// Shared sizes and codes for the sorted list table.
// ----------------------------------------------------------------------------
package slt_pkg;

    // Table depth and derived widths
    localparam int CAPACITY  = 16;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int VAL_W     = 32;
    localparam int KIND_W    = 2;
    localparam int STAT_W    = 2;
    localparam int OUT_CNT_W = 5;

    // Operation codes
    localparam logic [KIND_W-1:0] OP_INSERT    = 2'd0;
    localparam logic [KIND_W-1:0] OP_DEL_HEAD  = 2'd1;
    localparam logic [KIND_W-1:0] OP_DEL_VALUE = 2'd2;
    localparam logic [KIND_W-1:0] OP_CLEAR     = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_MISSING = 2'd2;

    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [IDX_W-1:0] t_idx;
    typedef logic signed [VAL_W-1:0] t_val;

endpackage

/* rtl/sorted_list_table_core.sv */
// ----------------------------------------------------------------------------
// sorted_list_table_core
// Sorted table of signed values held in one RAM with one read and one write port.
// ----------------------------------------------------------------------------
// The table keeps up to slt_pkg::CAPACITY signed 32-bit values in ascending
// order in a synchronous RAM (one read and one write per cycle, with registered
// read data). One input word carries an operation and a value; one result
// word comes back for each. Only one operation is in flight at a time: the
// input stalls from acceptance until the result is loaded into the output
// register, and a new word is taken while that result still waits there.
// The sequencer walks the RAM one entry per cycle:
//   insert        : walks down from the top of the N entries held,
//                   shifting larger-or-equal entries up one place
//   delete head   : compacting pass over all N entries
//   delete value  : same compacting pass
//   clear, refused insert, empty table : straight to the finish state
// The finish state waits while the output side stalls. No clearing pass is
// needed at reset: entries above the held count are never read.
// ----------------------------------------------------------------------------
module sorted_list_table_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [slt_pkg::KIND_W-1:0]   i_kind,
    input  logic signed [slt_pkg::VAL_W-1:0] i_value,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [slt_pkg::STAT_W-1:0]   o_status,
    output logic signed [slt_pkg::VAL_W-1:0] o_removed_value,
    output logic [slt_pkg::OUT_CNT_W-1:0] o_removed_count,
    output logic [slt_pkg::OUT_CNT_W-1:0] o_entry_count
);

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INS      = 3'd1;  // walk down, shift up
    localparam logic [2:0] S_INS_LAST = 3'd2;  // value lands at the bottom slot
    localparam logic [2:0] S_CMP      = 3'd3;  // compacting pass for deletes
    localparam logic [2:0] S_FIN      = 3'd4;  // hand result to output register

    localparam slt_pkg::t_cnt CAP_CNT = slt_pkg::CNT_W'(slt_pkg::CAPACITY);

    // table RAM
    slt_pkg::t_val mem [slt_pkg::CAPACITY];

    logic [2:0]                   r_state, n_state;
    logic [slt_pkg::KIND_W-1:0]   r_kind, n_kind;
    slt_pkg::t_val                r_val, n_val;
    slt_pkg::t_idx                r_ptr, n_ptr;    // index of word now in r_rd
    slt_pkg::t_cnt                r_wr, n_wr;      // compaction write index
    slt_pkg::t_cnt                r_count, n_count;
    slt_pkg::t_cnt                r_rem_cnt, n_rem_cnt;
    slt_pkg::t_val                r_rem_val, n_rem_val;
    logic [slt_pkg::STAT_W-1:0]   r_status, n_status;
    slt_pkg::t_val                r_rd;            // registered RAM read data

    // RAM port controls
    logic                         w_re, w_we;
    slt_pkg::t_idx                w_ra, w_wa;
    slt_pkg::t_val                w_wd;

    logic                         w_in_acc;
    logic                         w_out_free;
    logic                         w_skip;
    logic                         w_last;
    slt_pkg::t_cnt                w_rem_next;

    // output register
    logic                         r_out_valid;
    logic [slt_pkg::STAT_W-1:0]   r_o_status;
    slt_pkg::t_val                r_o_rem_val;
    slt_pkg::t_cnt                r_o_rem_cnt;
    slt_pkg::t_cnt                r_o_count;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !(r_out_valid && i_out_stall);

    // compaction decisions: head delete drops slot 0, value delete drops matches
    assign w_skip = (r_kind == slt_pkg::OP_DEL_HEAD) ? (r_ptr == '0) : (r_rd == r_val);
    assign w_last = ((slt_pkg::CNT_W'(r_ptr) + slt_pkg::CNT_W'(1)) == r_count);
    assign w_rem_next = w_skip ? (r_rem_cnt + slt_pkg::CNT_W'(1)) : r_rem_cnt;

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_val     = r_val;
        n_ptr     = r_ptr;
        n_wr      = r_wr;
        n_count   = r_count;
        n_rem_cnt = r_rem_cnt;
        n_rem_val = r_rem_val;
        n_status  = r_status;
        w_re      = 1'b0;
        w_ra      = '0;
        w_we      = 1'b0;
        w_wa      = '0;
        w_wd      = r_val;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_kind    = i_kind;
                    n_val     = i_value;
                    n_rem_cnt = '0;
                    n_rem_val = '0;
                    n_status  = slt_pkg::ST_DONE;
                    n_wr      = '0;
                    unique case (i_kind)
                        slt_pkg::OP_INSERT: begin
                            if (r_count == CAP_CNT) begin
                                n_status = slt_pkg::ST_FULL;
                                n_state  = S_FIN;
                            end else if (r_count == '0) begin
                                w_we    = 1'b1;
                                w_wa    = '0;
                                w_wd    = i_value;
                                n_count = slt_pkg::CNT_W'(1);
                                n_state = S_FIN;
                            end else begin
                                // start at the top entry
                                w_re    = 1'b1;
                                w_ra    = slt_pkg::IDX_W'(r_count - slt_pkg::CNT_W'(1));
                                n_ptr   = w_ra;
                                n_state = S_INS;
                            end
                        end
                        slt_pkg::OP_DEL_HEAD, slt_pkg::OP_DEL_VALUE: begin
                            if (r_count == '0) begin
                                n_status = slt_pkg::ST_MISSING;
                                n_state  = S_FIN;
                            end else begin
                                w_re    = 1'b1;
                                w_ra    = '0;
                                n_ptr   = '0;
                                n_state = S_CMP;
                            end
                        end
                        default: begin
                            // clear
                            n_rem_cnt = r_count;
                            n_count   = '0;
                            n_state   = S_FIN;
                        end
                    endcase
                end
            end

            S_INS: begin
                w_we = 1'b1;
                w_wa = r_ptr + slt_pkg::IDX_W'(1);
                if (r_rd >= r_val) begin
                    // entry moves up; value goes below it
                    w_wd = r_rd;
                    if (r_ptr == '0) begin
                        n_state = S_INS_LAST;
                    end else begin
                        w_re  = 1'b1;
                        w_ra  = r_ptr - slt_pkg::IDX_W'(1);
                        n_ptr = w_ra;
                    end
                end else begin
                    w_wd    = r_val;
                    n_count = r_count + slt_pkg::CNT_W'(1);
                    n_state = S_FIN;
                end
            end

            S_INS_LAST: begin
                w_we    = 1'b1;
                w_wa    = '0;
                w_wd    = r_val;
                n_count = r_count + slt_pkg::CNT_W'(1);
                n_state = S_FIN;
            end

            S_CMP: begin
                n_rem_cnt = w_rem_next;
                if (w_skip) begin
                    if (r_kind == slt_pkg::OP_DEL_HEAD) begin
                        n_rem_val = r_rd;
                    end
                end else begin
                    w_we = 1'b1;
                    w_wa = r_wr[slt_pkg::IDX_W-1:0];
                    w_wd = r_rd;
                    n_wr = r_wr + slt_pkg::CNT_W'(1);
                end
                if (w_last) begin
                    n_count  = n_wr;
                    n_status = (w_rem_next == '0) ? slt_pkg::ST_MISSING : slt_pkg::ST_DONE;
                    n_state  = S_FIN;
                end else begin
                    w_re  = 1'b1;
                    w_ra  = r_ptr + slt_pkg::IDX_W'(1);
                    n_ptr = w_ra;
                end
            end

            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // RAM: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rd <= mem[w_ra];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == S_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working and result payload
    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_val     <= n_val;
        r_ptr     <= n_ptr;
        r_wr      <= n_wr;
        r_rem_cnt <= n_rem_cnt;
        r_rem_val <= n_rem_val;
        r_status  <= n_status;
        if (r_state == S_FIN && w_out_free) begin
            r_o_status  <= r_status;
            r_o_rem_val <= r_rem_val;
            r_o_rem_cnt <= r_rem_cnt;
            r_o_count   <= r_count;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_removed_value = r_o_rem_val;
    assign o_removed_count = slt_pkg::OUT_CNT_W'(r_o_rem_cnt);
    assign o_entry_count   = slt_pkg::OUT_CNT_W'(r_o_count);

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("held count above capacity");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && w_re) |-> (w_wa != w_ra))
        else $error("RAM read and write hit the same entry");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_FIN))
        else $error("result loaded outside finish state");

    a_full_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_kind == slt_pkg::OP_INSERT && r_count == CAP_CNT)
            |=> (r_count == CAP_CNT && r_status == slt_pkg::ST_FULL))
        else $error("insert into full table changed the table");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state != S_IDLE))
        else $error("sequencer idle right after accepting a word");

endmodule
